// ----- hdl/fcd_pkg.sv -----
// Shared types and constants for the frame chunk decoder.
// No dependencies; imported by every module under hdl/.
package fcd_pkg;

    localparam int LINE_WIDTH = 320;
    localparam int LINE_COUNT = 200;
    localparam int FRAME_SIZE = LINE_WIDTH * LINE_COUNT;

    localparam int ROW_MAX    = 65535;
    localparam int COL_MAX    = 65535;
    localparam int ROW_BASE_W = $clog2(ROW_MAX * LINE_WIDTH + 1);
    localparam int ADDR_W     = $clog2(ROW_MAX * LINE_WIDTH + COL_MAX + 1);
    localparam int FRAME_W    = $clog2(FRAME_SIZE + 1);
    localparam int RUN_W      = 17;

    // register map (word index)
    localparam logic REG_DECODE_MODE = 1'b0;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_DONE    = 4'd1,
        PH_BR_HEAD = 4'd2,
        PH_BR_TYPE = 4'd3,
        PH_BR_LIT  = 4'd4,
        PH_BR_FILL = 4'd5,
        PH_LC_Y0   = 4'd6,
        PH_LC_Y1   = 4'd7,
        PH_LC_N0   = 4'd8,
        PH_LC_N1   = 4'd9,
        PH_LC_PKTS = 4'd10,
        PH_LC_XOFF = 4'd11,
        PH_LC_TYPE = 4'd12,
        PH_LC_LIT  = 4'd13,
        PH_LC_FILL = 4'd14,
        PH_LC_SKIP = 4'd15
    } phase_t;

    typedef enum logic {
        MODE_BYTE_RUN   = 1'b0,
        MODE_LINE_DELTA = 1'b1
    } mode_t;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] address;
        logic [7:0]  value;
        logic [7:0]  count;
    } wr_cmd_t;

endpackage

// ----- hdl/fcd_in_stage.sv -----
// Input register for chunk body bytes.
// Depends on fcd_pkg.
module fcd_in_stage
    import fcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  logic  [7:0] s_tdata,
    input  logic  s_tuser,
    input  logic  fire,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || fire;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.start <= s_tuser;
            item_reg.data  <= s_tdata;
        end
    end

endmodule

// ----- hdl/fcd_parser.sv -----
// Chunk parser: parse state registers and the per-byte decode logic.
// Depends on fcd_pkg.
module fcd_parser
    import fcd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  logic    decode_mode,
    output wr_cmd_t res
);

    phase_t                phase_reg, phase_next, eff_phase;
    logic [15:0]           row_reg, row_next, eff_row;
    logic [ROW_BASE_W-1:0] base_reg, base_next, eff_base;
    logic [15:0]           lines_reg, lines_next, eff_lines;
    logic [15:0]           col_reg, col_next, eff_col;
    logic [RUN_W-1:0]      run_reg, run_next, eff_run;
    logic [7:0]            pkts_reg, pkts_next, eff_pkts;
    logic [7:0]            lit_reg, lit_next, eff_lit;
    logic [7:0]            held_reg, held_next, eff_held;

    logic [7:0]        b;
    logic [7:0]        step;
    logic [16:0]       col_sum;
    logic [15:0]       col_sat;
    logic [RUN_W:0]    run_sum;
    logic [RUN_W-1:0]  run_sat;
    logic [7:0]        lit_dec;
    logic [7:0]        pkts_dec;
    logic [15:0]       lines_dec;
    logic [15:0]       row_sat;
    logic [ROW_BASE_W-1:0] base_inc;
    logic [15:0]       word;
    logic [ADDR_W-1:0] lc_addr;
    logic              pkt_end;
    logic              line_end;

    logic              em_req;
    logic [ADDR_W-1:0] em_addr;
    logic [7:0]        em_count;
    logic              in_frame;
    logic [ADDR_W-1:0] remain_full;
    logic [FRAME_W-1:0] remain;
    logic [7:0]        count_cl;

    assign b = item.data;

    // chunk_start restarts the parser before the byte is decoded
    always_comb
    begin
        eff_phase = phase_reg;
        eff_row   = row_reg;
        eff_base  = base_reg;
        eff_lines = lines_reg;
        eff_col   = col_reg;
        eff_run   = run_reg;
        eff_pkts  = pkts_reg;
        eff_lit   = lit_reg;
        eff_held  = held_reg;
        if (item.start)
        begin
            eff_row  = '0;
            eff_base = '0;
            eff_col  = '0;
            eff_run  = '0;
            eff_pkts = '0;
            eff_lit  = '0;
            eff_held = '0;
            if (decode_mode == MODE_BYTE_RUN)
            begin
                eff_lines = 16'(LINE_COUNT);
                eff_phase = (16'(LINE_COUNT) == 16'd0) ? PH_DONE : PH_BR_HEAD;
            end
            else
            begin
                eff_lines = '0;
                eff_phase = PH_LC_Y0;
            end
        end
    end

    // shared counter arithmetic
    always_comb
    begin
        if (eff_phase == PH_BR_LIT || eff_phase == PH_LC_LIT)
        begin
            step = 8'd1;
        end
        else if (eff_phase == PH_LC_SKIP)
        begin
            step = b;
        end
        else
        begin
            step = eff_lit;
        end
    end

    assign col_sum   = {1'b0, eff_col} + 17'(step);
    assign col_sat   = col_sum[16] ? 16'hFFFF : col_sum[15:0];
    assign run_sum   = {1'b0, eff_run} + (RUN_W + 1)'(step);
    assign run_sat   = run_sum[RUN_W] ? {RUN_W{1'b1}} : run_sum[RUN_W-1:0];
    assign lit_dec   = eff_lit - 8'd1;
    assign pkts_dec  = eff_pkts - 8'd1;
    assign lines_dec = eff_lines - 16'd1;
    assign row_sat   = (eff_row == 16'hFFFF) ? eff_row : eff_row + 16'd1;
    assign base_inc  = (eff_row == 16'hFFFF) ? eff_base
                                             : eff_base + ROW_BASE_W'(LINE_WIDTH);
    assign word      = {b, eff_held};
    assign lc_addr   = ADDR_W'(eff_base) + ADDR_W'(eff_col);

    always_comb
    begin
        phase_next = eff_phase;
        row_next   = eff_row;
        base_next  = eff_base;
        lines_next = eff_lines;
        col_next   = eff_col;
        run_next   = eff_run;
        pkts_next  = eff_pkts;
        lit_next   = eff_lit;
        held_next  = eff_held;
        pkt_end    = 1'b0;
        line_end   = 1'b0;
        em_req     = 1'b0;
        em_addr    = lc_addr;
        em_count   = 8'd1;

        unique case (eff_phase)
            PH_IDLE, PH_DONE:
            begin
            end
            PH_BR_HEAD:
            begin
                col_next   = '0;
                phase_next = PH_BR_TYPE;
            end
            PH_BR_TYPE:
            begin
                if (b[7])
                begin
                    lit_next   = 8'd0 - b;
                    phase_next = PH_BR_LIT;
                end
                else
                begin
                    lit_next   = b;
                    phase_next = PH_BR_FILL;
                end
            end
            PH_BR_LIT, PH_BR_FILL:
            begin
                em_req   = 1'b1;
                em_addr  = ADDR_W'(eff_run);
                em_count = (eff_phase == PH_BR_LIT) ? 8'd1 : eff_lit;
                run_next = run_sat;
                col_next = col_sat;
                if (eff_phase == PH_BR_LIT)
                begin
                    lit_next = lit_dec;
                end
                // packet ends after the last literal or after a fill
                if (eff_phase == PH_BR_FILL || lit_dec == 8'd0)
                begin
                    if (col_sat >= 16'(LINE_WIDTH))
                    begin
                        lines_next = lines_dec;
                        phase_next = (lines_dec == 16'd0) ? PH_DONE : PH_BR_HEAD;
                    end
                    else
                    begin
                        phase_next = PH_BR_TYPE;
                    end
                end
            end
            PH_LC_Y0:
            begin
                held_next  = b;
                phase_next = PH_LC_Y1;
            end
            PH_LC_Y1:
            begin
                row_next   = word;
                base_next  = ROW_BASE_W'(word) * ROW_BASE_W'(LINE_WIDTH);
                phase_next = PH_LC_N0;
            end
            PH_LC_N0:
            begin
                held_next  = b;
                phase_next = PH_LC_N1;
            end
            PH_LC_N1:
            begin
                lines_next = word;
                phase_next = (word == 16'd0) ? PH_DONE : PH_LC_PKTS;
            end
            PH_LC_PKTS:
            begin
                pkts_next = b;
                if (b == 8'd0)
                begin
                    line_end = 1'b1;
                end
                else
                begin
                    phase_next = PH_LC_XOFF;
                end
            end
            PH_LC_XOFF:
            begin
                col_next   = 16'(b);
                phase_next = PH_LC_TYPE;
            end
            PH_LC_TYPE:
            begin
                if (b != 8'd0 && !b[7])
                begin
                    lit_next   = b;
                    phase_next = PH_LC_LIT;
                end
                else
                begin
                    lit_next   = 8'd0 - b;
                    phase_next = PH_LC_FILL;
                end
            end
            PH_LC_LIT:
            begin
                em_req   = 1'b1;
                col_next = col_sat;
                lit_next = lit_dec;
                pkt_end  = (lit_dec == 8'd0);
            end
            PH_LC_FILL:
            begin
                em_req   = 1'b1;
                em_count = eff_lit;
                col_next = col_sat;
                pkt_end  = 1'b1;
            end
            PH_LC_SKIP:
            begin
                col_next   = col_sat;
                phase_next = PH_LC_TYPE;
            end
        endcase

        if (pkt_end)
        begin
            pkts_next = pkts_dec;
            if (pkts_dec == 8'd0)
            begin
                line_end = 1'b1;
            end
            else
            begin
                phase_next = PH_LC_SKIP;
            end
        end
        if (line_end)
        begin
            row_next   = row_sat;
            base_next  = base_inc;
            lines_next = lines_dec;
            phase_next = (lines_dec == 16'd0) ? PH_DONE : PH_LC_PKTS;
        end
    end

    // frame clipping: drop writes past the end, shorten fills that cross it
    assign in_frame    = (em_addr < ADDR_W'(FRAME_SIZE));
    assign remain_full = ADDR_W'(FRAME_SIZE) - em_addr;
    assign remain      = remain_full[FRAME_W-1:0];
    assign count_cl    = (FRAME_W'(em_count) > remain) ? remain[7:0] : em_count;

    always_comb
    begin
        res.valid   = fire && em_req && (em_count != 8'd0) && in_frame;
        res.address = em_addr[15:0];
        res.value   = b;
        res.count   = count_cl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            row_reg   <= '0;
            base_reg  <= '0;
            lines_reg <= '0;
            col_reg   <= '0;
            run_reg   <= '0;
            pkts_reg  <= '0;
            lit_reg   <= '0;
            held_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            base_reg  <= base_next;
            lines_reg <= lines_next;
            col_reg   <= col_next;
            run_reg   <= run_next;
            pkts_reg  <= pkts_next;
            lit_reg   <= lit_next;
            held_reg  <= held_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.count != 8'd0) && (res.count <= 8'd128))
        else $error("write count out of range");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.start && (phase_reg == PH_IDLE || phase_reg == PH_DONE))
        |-> !res.valid)
        else $error("write issued while parser idle or done");

    a_base_track: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg == ROW_BASE_W'(row_reg) * ROW_BASE_W'(LINE_WIDTH))
        else $error("row base out of step with row index");

endmodule

// ----- hdl/fcd_out_stage.sv -----
// Result register holding one write command for the output stream.
// Depends on fcd_pkg.
module fcd_out_stage
    import fcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  wr_cmd_t     res,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] data_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = res.valid;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
        begin
            data_reg <= {res.count, res.value, res.address};
        end
    end

endmodule

// ----- hdl/fli_frame_chunk_decoder_core.sv -----
// Frame chunk decoder top; depends on fcd_pkg, fcd_in_stage, fcd_parser, fcd_out_stage.
// Pipeline: an input transfer enters the input reg, and its write command then
//   reaches the result reg, which drives m_tvalid.
// Throughput: one body byte per cycle; the input stalls only while a full input
//   reg waits behind a result that is not taken.
// Reset (rst_n, async low): pipeline empty, parser idle, decode_mode = 0.
module fli_frame_chunk_decoder_core
    import fcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // chunk body stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] chunk_start
    // write command stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] write_address, [23:16] write_value,
                                   // [31:24] write_count
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic    mode_reg;
    logic    mode_next;
    logic    item_valid;
    item_t   item;
    logic    out_free;
    logic    fire;
    wr_cmd_t res;

    // --- register port: no wait states, decode_mode at word 0 ---
    assign pready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_DECODE_MODE))
        begin
            mode_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_DECODE_MODE)
        begin
            prdata = {31'd0, mode_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BYTE_RUN;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // --- pipeline control ---
    // A held byte is decoded once the result register is empty or draining;
    // the input register refills in the same cycle. A result stalled on the
    // output backs up into the input only once the input register is full.
    assign out_free = !m_tvalid || m_tready;
    assign fire     = item_valid && out_free;

    fcd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    // parse state advances only on fire; decode_mode is sampled on the
    // chunk_start byte through the restart logic
    fcd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item),
        .decode_mode (mode_reg),
        .res         (res)
    );

    fcd_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (item_valid && m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(fire))
        else $error("result appeared without a decoded byte");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !fire) |=> item_valid)
        else $error("undecoded byte dropped from input register");

endmodule

// ----- tb/fli_frame_chunk_decoder_core_tb.sv -----
// Self-checking testbench for fli_frame_chunk_decoder_core: byte-run and line-delta
// chunk bodies in, frame-buffer write commands out, checked against a local decoder.
// Depends on fcd_pkg and the core RTL only.
`timescale 1ns / 100ps

module fli_frame_chunk_decoder_core_tb;
    import fcd_pkg::*;

    localparam logic [2:0] MODE_ADDR   = 3'(REG_DECODE_MODE) << 2;
    localparam int         SETTLE_CYC  = 6;       // idle wait after the write queue drains
    localparam int         DRAIN_LIMIT = 20000;   // cycles to wait for stragglers

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_kind_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  value;
        logic [7:0]  count;
    } pixel_write_t;

    // ---------------------------------------------------------------
    // DUT signals; every driven input starts at a known value
    // ---------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tuser  = 1'b0;    // [0] chunk_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [15:0] address, [23:16] value, [31:24] count
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    fli_frame_chunk_decoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // hard stop in case the core hangs
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Expected-write decoder: mirrors the parser state, one body byte at a time
    // ---------------------------------------------------------------
    mode_t        cfg_mode = MODE_BYTE_RUN;   // shadow of the decode_mode register
    phase_t       pr_phase = PH_IDLE;
    logic [15:0]  pr_row   = '0;
    logic [15:0]  pr_lines = '0;
    logic [15:0]  pr_col   = '0;
    logic [16:0]  pr_run   = '0;
    logic [7:0]   pr_pkts  = '0;
    logic [7:0]   pr_lit   = '0;
    logic [7:0]   pr_held  = '0;

    pixel_write_t pending_writes[$];
    int           fail_count = 0;

    function automatic logic [15:0] sat16(int unsigned a, int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
    endfunction

    // drop writes starting past the frame, clip fills that cross its end
    function automatic void queue_write(int unsigned addr, logic [7:0] value,
                                        int unsigned count);
        pixel_write_t w;
        if (count == 0 || addr >= FRAME_SIZE)
            return;
        if (count > FRAME_SIZE - addr)
            count = FRAME_SIZE - addr;
        w.addr  = addr[15:0];
        w.value = value;
        w.count = count[7:0];
        pending_writes.push_back(w);
    endfunction

    function automatic void br_advance(int unsigned n);
        pr_run = (pr_run + n > 32'h1FFFF) ? 17'h1FFFF : 17'(pr_run + n);
        pr_col = sat16(pr_col, n);
    endfunction

    // byte-run: a line closes once it holds a full width (overrun carries on)
    function automatic void br_packet_end();
        if (pr_col >= LINE_WIDTH)
        begin
            pr_lines = pr_lines - 16'd1;
            pr_phase = (pr_lines == 0) ? PH_DONE : PH_BR_HEAD;
        end
        else
        begin
            pr_phase = PH_BR_TYPE;
        end
    endfunction

    function automatic void lc_line_end();
        pr_row   = sat16(pr_row, 1);
        pr_lines = pr_lines - 16'd1;
        pr_phase = (pr_lines == 0) ? PH_DONE : PH_LC_PKTS;
    endfunction

    function automatic void lc_packet_end();
        pr_pkts = pr_pkts - 8'd1;
        if (pr_pkts == 0)
            lc_line_end();
        else
            pr_phase = PH_LC_SKIP;
    endfunction

    function automatic void decode_body_byte(logic [7:0] b, logic start);
        int unsigned lc_addr;
        if (start)
        begin
            pr_row  = '0;
            pr_col  = '0;
            pr_run  = '0;
            pr_pkts = '0;
            pr_lit  = '0;
            pr_held = '0;
            if (cfg_mode == MODE_BYTE_RUN)
            begin
                pr_lines = 16'(LINE_COUNT);
                pr_phase = PH_BR_HEAD;
            end
            else
            begin
                pr_lines = '0;
                pr_phase = PH_LC_Y0;
            end
        end
        lc_addr = pr_row * LINE_WIDTH + pr_col;   // line-delta spills linearly
        case (pr_phase)
            PH_BR_HEAD:
            begin
                pr_col   = '0;
                pr_phase = PH_BR_TYPE;
            end
            PH_BR_TYPE:
            begin
                if (b[7])
                begin
                    pr_lit   = 8'(9'h100 - b);
                    pr_phase = PH_BR_LIT;
                end
                else
                begin
                    pr_lit   = b;
                    pr_phase = PH_BR_FILL;
                end
            end
            PH_BR_LIT:
            begin
                queue_write(pr_run, b, 1);
                br_advance(1);
                pr_lit = pr_lit - 8'd1;
                if (pr_lit == 0)
                    br_packet_end();
            end
            PH_BR_FILL:
            begin
                queue_write(pr_run, b, pr_lit);
                br_advance(pr_lit);
                br_packet_end();
            end
            PH_LC_Y0:
            begin
                pr_held  = b;
                pr_phase = PH_LC_Y1;
            end
            PH_LC_Y1:
            begin
                pr_row   = {b, pr_held};
                pr_phase = PH_LC_N0;
            end
            PH_LC_N0:
            begin
                pr_held  = b;
                pr_phase = PH_LC_N1;
            end
            PH_LC_N1:
            begin
                pr_lines = {b, pr_held};
                pr_phase = (pr_lines == 0) ? PH_DONE : PH_LC_PKTS;
            end
            PH_LC_PKTS:
            begin
                pr_pkts = b;
                if (b == 0)
                    lc_line_end();
                else
                    pr_phase = PH_LC_XOFF;
            end
            PH_LC_XOFF:
            begin
                pr_col   = {8'h00, b};
                pr_phase = PH_LC_TYPE;
            end
            PH_LC_TYPE:
            begin
                if (b != 0 && !b[7])
                begin
                    pr_lit   = b;
                    pr_phase = PH_LC_LIT;
                end
                else
                begin
                    pr_lit   = 8'(9'h100 - b);   // type zero gives an empty fill
                    pr_phase = PH_LC_FILL;
                end
            end
            PH_LC_LIT:
            begin
                queue_write(lc_addr, b, 1);
                pr_col = sat16(pr_col, 1);
                pr_lit = pr_lit - 8'd1;
                if (pr_lit == 0)
                    lc_packet_end();
            end
            PH_LC_FILL:
            begin
                queue_write(lc_addr, b, pr_lit);
                pr_col = sat16(pr_col, pr_lit);
                lc_packet_end();
            end
            PH_LC_SKIP:
            begin
                pr_col   = sat16(pr_col, b);
                pr_phase = PH_LC_TYPE;
            end
            default: ;   // idle or done: byte ignored
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Result checker: every write-command transfer against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_write_t exp_w;
        pixel_write_t got;
        if (m_tvalid && m_tready)
        begin
            got.addr  = m_tdata[15:0];
            got.value = m_tdata[23:16];
            got.count = m_tdata[31:24];
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write command: address %0d value %0d count %0d",
                       got.addr, got.value, got.count);
                fail_count++;
            end
            else
            begin
                exp_w = pending_writes.pop_front();
                if (got.addr !== exp_w.addr)
                begin
                    $error("write_address: expected %0d, got %0d", exp_w.addr, got.addr);
                    fail_count++;
                end
                if (got.value !== exp_w.value)
                begin
                    $error("write_value: expected %0d, got %0d", exp_w.value, got.value);
                    fail_count++;
                end
                if (got.count !== exp_w.count)
                begin
                    $error("write_count: expected %0d, got %0d", exp_w.count, got.count);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall pattern picked per phase, plus an optional long hold-off
    // ---------------------------------------------------------------
    rx_kind_t rx_kind   = RX_RANDOM;
    int       hold_reqs = 0;   // bumped by the tests to ask for a long hold-off

    initial
    begin : receiver
        int cyc;
        int hold_seen;
        int hold_left;
        cyc       = 0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                case (rx_kind)
                    RX_ALWAYS:   m_tready <= 1'b1;
                    RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_tready <= ((cyc % 7) < 3);
                    default:     m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender: bursts with random gaps if tx_gaps is set; the expectation is built at the transfer
    // ---------------------------------------------------------------
    bit tx_gaps    = 1'b1;
    int burst_left = 0;
    int items_sent = 0;

    task automatic send_byte(input logic [7:0] b, input logic start);
        if (tx_gaps)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        decode_body_byte(b, start);
        items_sent++;
    endtask

    // packet type byte for a run of len (negative encodings)
    function automatic logic [7:0] neg_len(int len);
        return 8'(256 - len);
    endfunction

    // stop driving and wait for the pipeline to empty
    task automatic settle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_writes.size() != 0)
        begin
            $error("%0d write commands never arrived", pending_writes.size());
            fail_count++;
            pending_writes.delete();
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] data,
                              output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MODE_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rd = prdata;
        @(posedge clk);       // access completes here
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (wr)
            cfg_mode = mode_t'(data[0]);
    endtask

    // mode changes only while the core is idle; read back after each write
    task automatic set_mode(input mode_t m);
        logic [31:0] rd;
        settle();
        apb_access(1'b1, {31'b0, m}, rd);
        apb_access(1'b0, 32'd0, rd);
        if (rd !== {31'b0, cfg_mode})
        begin
            $error("decode_mode readback: expected %0d, got %0d", cfg_mode, rd);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // Chunk generators
    // ---------------------------------------------------------------

    // byte-run chunk covering n_lines lines; may break off mid-line
    task automatic gen_br_chunk(input int n_lines, input int fill_min, input bit may_abort);
        int col;
        int len;
        send_byte(8'($urandom), 1'b1);          // skipped line-count byte
        for (int ln = 0; ln < n_lines; ln++)
        begin
            if (ln > 0)
                send_byte(8'($urandom), 1'b0);  // per-line head, also skipped
            col = 0;
            while (col < LINE_WIDTH)
            begin
                if (may_abort && $urandom_range(0, 49) == 0)
                    return;
                if ($urandom_range(0, 3) == 0)
                begin
                    len = ($urandom_range(0, 31) == 0) ? 128 : $urandom_range(1, 8);
                    send_byte(neg_len(len), 1'b0);
                    repeat (len) send_byte(8'($urandom), 1'b0);
                end
                else
                begin
                    len = $urandom_range(fill_min, 127);
                    send_byte(8'(len), 1'b0);
                    send_byte(8'($urandom), 1'b0);
                end
                col += len;
            end
        end
    endtask

    // line-delta chunk with random header; sends at most four lines
    task automatic gen_lc_chunk(input bit may_abort);
        logic [15:0] y0;
        logic [15:0] n;
        int          pk;
        int          sel;
        int          len;
        case ($urandom_range(0, 19))
            0, 1, 2:    y0 = 16'($urandom);
            3, 4, 5, 6: y0 = 16'($urandom_range(180, 300));
            default:    y0 = 16'($urandom_range(0, 199));
        endcase
        case ($urandom_range(0, 19))
            0:       n = 16'd0;
            1, 2:    n = 16'($urandom);        // declared long, sent short
            default: n = 16'($urandom_range(1, 4));
        endcase
        send_byte(y0[7:0], 1'b1);
        send_byte(y0[15:8], 1'b0);
        send_byte(n[7:0], 1'b0);
        send_byte(n[15:8], 1'b0);
        for (int ln = 0; ln < n && ln < 4; ln++)
        begin
            pk = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            send_byte(8'(pk), 1'b0);
            if (pk != 0)
            begin
                send_byte(8'($urandom), 1'b0);  // start column
                for (int p = 0; p < pk; p++)
                begin
                    if (may_abort && $urandom_range(0, 39) == 0)
                        return;
                    sel = $urandom_range(0, 19);
                    if (sel < 10)
                    begin
                        len = (sel == 9) ? $urandom_range(1, 127) : $urandom_range(1, 6);
                        send_byte(8'(len), 1'b0);
                        repeat (len) send_byte(8'($urandom), 1'b0);
                    end
                    else
                    begin
                        // fill: type zero is an empty fill, 0x80 the longest
                        len = (sel == 10) ? 0 : $urandom_range(1, 128);
                        send_byte(neg_len(len), 1'b0);
                        send_byte(8'($urandom), 1'b0);
                    end
                    if (p < pk - 1)
                        send_byte(8'($urandom), 1'b0);  // column skip
                end
            end
        end
    endtask

    task automatic gen_noise(input int cnt);
        repeat (cnt) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // before any chunk start the parser is idle and ignores bytes
    task automatic test_idle_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // byte-run: literal, empty fill, longest fill, short fill, restart mid-line
    task automatic test_byte_run_packets();
        send_byte(8'hA5, 1'b1);
        send_byte(neg_len(2), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);          // zero-length fill
        send_byte(8'h3C, 1'b0);
        send_byte(8'h7F, 1'b0);          // fill 127
        send_byte(8'h81, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h11, 1'b1);          // new chunk restarts the parser
        send_byte(neg_len(1), 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    // line-delta: header, literal, skip, empty fill, fill 128, empty line, done
    task automatic test_line_delta_packets();
        send_byte(8'h01, 1'b1);          // start line 1
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);          // two lines
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);          // three packets
        send_byte(8'h10, 1'b0);
        send_byte(8'h02, 1'b0);          // literal 2
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h00, 1'b0);          // zero-length fill
        send_byte(8'h99, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);          // fill 128
        send_byte(8'h66, 1'b0);
        send_byte(8'h00, 1'b0);          // second line: no packets
        send_byte(8'h33, 1'b0);          // after the decode finishes: ignored
    endtask

    // zero line count ends the decode right after the header
    task automatic test_line_delta_zero_lines();
        send_byte(8'h05, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'hEE, 1'b0);
    endtask

    // frame edge: row spill, clipped fill, writes past the end, row counter limit
    task automatic test_line_delta_frame_edge();
        // line 10 column 255, fill 127 runs into line 11
        send_byte(8'h0A, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(neg_len(127), 1'b0);
        send_byte(8'h42, 1'b0);
        // last line: fill clipped at the frame end, then a literal beyond it
        send_byte(8'(LINE_COUNT - 1), 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hFA, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        // start line near the top of the row counter: it must saturate
        send_byte(8'hFE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        repeat (3)
        begin
            send_byte(8'h01, 1'b0);
            send_byte(8'h00, 1'b0);
            send_byte(8'h01, 1'b0);
            send_byte(8'h77, 1'b0);
        end
    endtask

    // long line of fills and maximal skips drives the column counter to its limit
    task automatic test_column_limit();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        repeat (180)
        begin
            send_byte(8'h80, 1'b0);
            send_byte(8'($urandom), 1'b0);
            send_byte(8'hFF, 1'b0);
        end
    endtask

    // random phases, alternating mode, receiver pattern and sender gaps
    task automatic test_random_chunks();
        int target;
        int sel;
        for (int ph = 0; ph < 8; ph++)
        begin
            set_mode(mode_t'(ph[0]));
            if (ph == 0)
            begin
                rx_kind = RX_ALWAYS;
                tx_gaps = 1'b0;
            end
            else
            begin
                rx_kind = rx_kind_t'($urandom_range(0, 3));
                tx_gaps = ($urandom_range(0, 3) != 0);
            end
            // receiver holds off long enough to back up the input side
            if (ph == 3)
                hold_reqs++;
            target = items_sent + 80;
            while (items_sent < target)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 3)
                    gen_noise($urandom_range(1, 8));
                else if (cfg_mode == MODE_BYTE_RUN)
                    gen_br_chunk($urandom_range(1, 3), 0, 1'b1);
                else
                    gen_lc_chunk(1'b1);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_bytes();
        test_byte_run_packets();
        set_mode(MODE_LINE_DELTA);
        test_line_delta_packets();
        test_line_delta_zero_lines();
        test_line_delta_frame_edge();
        test_column_limit();
        test_random_chunks();

        settle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
